// ===== rtl/fdb_pkg.sv =====
`default_nettype none

package fdb_pkg;

    localparam int MAX_COLS   = 2048;
    localparam int MAX_ROWS   = 2048;
    localparam int LANES      = 8;
    localparam int PIX_W      = 4;
    localparam int BYTE_W     = 2 * PIX_W;
    localparam int WORD_W     = LANES * PIX_W;
    localparam int INTER_W    = LANES * BYTE_W;
    localparam int COORD_W    = 12;
    localparam int SUM_W      = COORD_W + 1;
    localparam int LANE_IDX_W = $clog2(LANES);
    localparam int SEG_ALIGN  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int ORG_W      = 11;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_SPAN_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_SPAN_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS  = 3'd5;

    localparam logic [ORG_W-1:0]      RST_CROP_LEFT   = 11'd0;
    localparam logic [ORG_W-1:0]      RST_CROP_TOP    = 11'd0;
    localparam logic [CFG_DATA_W-1:0] RST_CROP_SPAN_X = 12'd2048;
    localparam logic [CFG_DATA_W-1:0] RST_CROP_SPAN_Y = 12'd2048;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_COLS  = 12'd2048;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_ROWS  = 12'd2048;

    typedef struct packed {
        logic [WORD_W-1:0] new_word;
        logic [WORD_W-1:0] old_word;
    } t_in_beat;

    typedef struct packed {
        logic [INTER_W-1:0] interlaced_pixels;
        logic               row_end;
        logic               row_changed;
        logic               frame_end;
        logic [COORD_W-1:0] box_x;
        logic [COORD_W-1:0] box_y;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
    } t_out_beat;

    // derived crop / segment bounds, held in registers
    typedef struct packed {
        logic [SUM_W-1:0] seg_start;
        logic [SUM_W-1:0] seg_end;
        logic [SUM_W-1:0] x_end;
        logic [SUM_W-1:0] y_end;
        logic [SUM_W-1:0] crop_left;
        logic [SUM_W-1:0] crop_top;
        logic [SUM_W-1:0] empty_x;
        logic [SUM_W-1:0] empty_y;
    } t_bounds;

    typedef struct packed {
        logic               restart;
        logic [COORD_W-1:0] seg_start;
        logic [COORD_W-1:0] crop_top;
    } t_cfg_ctl;

    typedef struct packed {
        logic diff;
        logic track;
    } t_lane_flags;

    typedef struct packed {
        logic                  any_diff;
        logic                  any_track;
        logic [LANE_IDX_W-1:0] first_idx;
        logic [LANE_IDX_W-1:0] last_idx;
    } t_merge;

    function automatic t_bounds calc_bounds(
        input logic [ORG_W-1:0]      cl,
        input logic [ORG_W-1:0]      ct,
        input logic [CFG_DATA_W-1:0] sx,
        input logic [CFG_DATA_W-1:0] sy,
        input logic [CFG_DATA_W-1:0] fc,
        input logic [CFG_DATA_W-1:0] fr
    );
        t_bounds          b;
        logic [SUM_W-1:0] eff_c;
        logic [SUM_W-1:0] eff_r;
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SUM_W-1:0] seg_hi;
        logic [SUM_W-1:0] seg_lo;
        logic [SUM_W-1:0] align_m;
        align_m = SUM_W'(SEG_ALIGN - 1);
        eff_c = (SUM_W'(fc) > SUM_W'(MAX_COLS)) ? SUM_W'(MAX_COLS) : SUM_W'(fc);
        eff_r = (SUM_W'(fr) > SUM_W'(MAX_ROWS)) ? SUM_W'(MAX_ROWS) : SUM_W'(fr);
        sum_x = SUM_W'(cl) + SUM_W'(sx);
        sum_y = SUM_W'(ct) + SUM_W'(sy);
        seg_lo = SUM_W'(cl) & ~align_m;
        seg_hi = (sum_x + align_m) & ~align_m;
        if (seg_hi > eff_c) seg_hi = eff_c;
        if (seg_hi < seg_lo) seg_hi = seg_lo;
        b.seg_start = seg_lo;
        b.seg_end   = seg_hi;
        b.x_end     = (sum_x < eff_c) ? sum_x : eff_c;
        b.y_end     = (sum_y < eff_r) ? sum_y : eff_r;
        b.crop_left = SUM_W'(cl);
        b.crop_top  = SUM_W'(ct);
        b.empty_x   = (b.crop_left > b.x_end) ? b.crop_left : b.x_end;
        b.empty_y   = (b.crop_top > b.y_end) ? b.crop_top : b.y_end;
        return b;
    endfunction

    localparam t_bounds RST_BOUNDS = calc_bounds(RST_CROP_LEFT, RST_CROP_TOP,
        RST_CROP_SPAN_X, RST_CROP_SPAN_Y, RST_FRAME_COLS, RST_FRAME_ROWS);

endpackage

`default_nettype wire

// ===== rtl/fdb_cfg.sv =====
`default_nettype none

module fdb_cfg
    import fdb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_bounds                    o_bounds,
    output t_cfg_ctl                   o_ctl
);

    logic [ORG_W-1:0]      r_crop_left,   n_crop_left;
    logic [ORG_W-1:0]      r_crop_top,    n_crop_top;
    logic [CFG_DATA_W-1:0] r_crop_span_x, n_crop_span_x;
    logic [CFG_DATA_W-1:0] r_crop_span_y, n_crop_span_y;
    logic [CFG_DATA_W-1:0] r_frame_cols,  n_frame_cols;
    logic [CFG_DATA_W-1:0] r_frame_rows,  n_frame_rows;
    t_bounds               r_bounds,      n_bounds;
    logic                  w_hit;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_crop_left   = r_crop_left;
        n_crop_top    = r_crop_top;
        n_crop_span_x = r_crop_span_x;
        n_crop_span_y = r_crop_span_y;
        n_frame_cols  = r_frame_cols;
        n_frame_rows  = r_frame_rows;
        w_hit         = 1'b0;
        if (i_cfg_valid) begin
            w_hit = 1'b1;
            unique case (i_cfg_index)
                CFG_CROP_LEFT:   n_crop_left   = i_cfg_data[ORG_W-1:0];
                CFG_CROP_TOP:    n_crop_top    = i_cfg_data[ORG_W-1:0];
                CFG_CROP_SPAN_X: n_crop_span_x = i_cfg_data;
                CFG_CROP_SPAN_Y: n_crop_span_y = i_cfg_data;
                CFG_FRAME_COLS:  n_frame_cols  = i_cfg_data;
                CFG_FRAME_ROWS:  n_frame_rows  = i_cfg_data;
                default:         w_hit         = 1'b0;
            endcase
        end
        n_bounds = calc_bounds(n_crop_left, n_crop_top, n_crop_span_x,
                               n_crop_span_y, n_frame_cols, n_frame_rows);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crop_left   <= RST_CROP_LEFT;
            r_crop_top    <= RST_CROP_TOP;
            r_crop_span_x <= RST_CROP_SPAN_X;
            r_crop_span_y <= RST_CROP_SPAN_Y;
            r_frame_cols  <= RST_FRAME_COLS;
            r_frame_rows  <= RST_FRAME_ROWS;
            r_bounds      <= RST_BOUNDS;
        end else if (w_hit) begin
            r_crop_left   <= n_crop_left;
            r_crop_top    <= n_crop_top;
            r_crop_span_x <= n_crop_span_x;
            r_crop_span_y <= n_crop_span_y;
            r_frame_cols  <= n_frame_cols;
            r_frame_rows  <= n_frame_rows;
            r_bounds      <= n_bounds;
        end
    end

    assign o_bounds          = r_bounds;
    assign o_ctl.restart     = w_hit;
    assign o_ctl.seg_start   = n_bounds.seg_start[COORD_W-1:0];
    assign o_ctl.crop_top    = n_bounds.crop_top[COORD_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/fdb_lane.sv =====
`default_nettype none

module fdb_lane
    import fdb_pkg::*;
(
    input  wire logic [PIX_W-1:0] i_new_pix,
    input  wire logic [PIX_W-1:0] i_old_pix,
    input  wire logic [SUM_W-1:0] i_col,
    input  wire t_bounds          i_bounds,
    output logic [BYTE_W-1:0]     o_byte,
    output t_lane_flags           o_flags
);

    assign o_byte        = {i_new_pix, i_old_pix};
    // pixels past the segment end are interlaced only
    assign o_flags.diff  = (i_new_pix != i_old_pix) && (i_col < i_bounds.seg_end);
    assign o_flags.track = o_flags.diff && (i_col >= i_bounds.crop_left)
                           && (i_col < i_bounds.x_end);

endmodule

`default_nettype wire

// ===== rtl/fdb_merge.sv =====
`default_nettype none

module fdb_merge
    import fdb_pkg::*;
(
    input  wire logic [LANES-1:0] i_diff,
    input  wire logic [LANES-1:0] i_track,
    output t_merge                o_merge
);

    always_comb begin
        o_merge.any_diff  = |i_diff;
        o_merge.any_track = |i_track;
        o_merge.first_idx = '0;
        o_merge.last_idx  = '0;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (i_track[k]) o_merge.first_idx = LANE_IDX_W'(k);
        end
        for (int k = 0; k < LANES; k++) begin
            if (i_track[k]) o_merge.last_idx = LANE_IDX_W'(k);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/frame_difference_dirty_box_unit.sv =====
// Channel  Dir  Handshake               Payload
// in       in   i_in_valid / o_in_stall  i_in_data  (t_in_beat: new_word, old_word)
// out      out  o_out_valid / i_out_stall o_out_data (t_out_beat: pixels, flags, box)
// cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One beat per cycle unless stalled; each result appears in the cycle after its
// input beat, from the output register fed by the eight pixel lanes and the merge.
// Input stalls only while the output register is full and stalled downstream.
// Synchronous active-low reset restores register defaults and restarts the frame.
// Each write to a defined config index restarts the frame and recomputes the bounds.
`default_nettype none

module frame_difference_dirty_box_unit
    import fdb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_beat              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_beat                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_bounds  w_bounds;
    t_cfg_ctl w_ctl;

    fdb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_bounds    (w_bounds),
        .o_ctl       (w_ctl)
    );

    // frame scan state
    logic [COORD_W-1:0] r_col_cursor, n_col_cursor;
    logic [COORD_W-1:0] r_row_cursor, n_row_cursor;
    logic               r_row_diff,   n_row_diff;
    logic               r_col_any,    n_col_any;
    logic               r_row_any,    n_row_any;
    logic [COORD_W-1:0] r_first_col,  n_first_col;
    logic [COORD_W-1:0] r_last_col,   n_last_col;
    logic [COORD_W-1:0] r_first_row,  n_first_row;
    logic [COORD_W-1:0] r_last_row,   n_last_row;

    logic      r_out_valid;
    t_out_beat r_out, n_out;

    logic w_fire;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_fire     = i_in_valid && !o_in_stall;

    // lanes: one pixel pair each, column = cursor + lane
    logic [INTER_W-1:0] w_inter;
    logic [LANES-1:0]   w_diff;
    logic [LANES-1:0]   w_track;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        t_lane_flags w_flags;
        fdb_lane u_lane (
            .i_new_pix (i_in_data.new_word[k*PIX_W +: PIX_W]),
            .i_old_pix (i_in_data.old_word[k*PIX_W +: PIX_W]),
            .i_col     (SUM_W'(r_col_cursor) + SUM_W'(k)),
            .i_bounds  (w_bounds),
            .o_byte    (w_inter[k*BYTE_W +: BYTE_W]),
            .o_flags   (w_flags)
        );
        assign w_diff[k]  = w_flags.diff;
        assign w_track[k] = w_flags.track;
    end

    t_merge w_merge;

    fdb_merge u_merge (
        .i_diff  (w_diff),
        .i_track (w_track),
        .o_merge (w_merge)
    );

    logic w_row_end;
    logic w_frame_end;
    logic w_row_diff;
    logic w_row_hit;
    logic w_col_any;
    logic w_row_any;
    logic [COORD_W-1:0] w_first_col;
    logic [COORD_W-1:0] w_last_col;
    logic [COORD_W-1:0] w_first_row;
    logic [COORD_W-1:0] w_last_row;

    always_comb begin
        w_row_end   = (SUM_W'(r_col_cursor) + SUM_W'(LANES)) >= w_bounds.seg_end;
        w_frame_end = w_row_end && ((SUM_W'(r_row_cursor) + SUM_W'(1)) >= w_bounds.y_end);
        w_row_diff  = r_row_diff || w_merge.any_diff;

        // column extent, this beat folded in
        w_col_any   = r_col_any || w_merge.any_track;
        w_first_col = r_col_any ? r_first_col
                                : r_col_cursor + COORD_W'(w_merge.first_idx);
        w_last_col  = w_merge.any_track ? r_col_cursor + COORD_W'(w_merge.last_idx)
                                        : r_last_col;

        // row extent: only rows below y_end are tracked
        w_row_hit   = w_row_end && w_row_diff
                      && (SUM_W'(r_row_cursor) < w_bounds.y_end);
        w_row_any   = r_row_any || w_row_hit;
        w_first_row = r_row_any ? r_first_row : r_row_cursor;
        w_last_row  = w_row_hit ? r_row_cursor : r_last_row;

        n_out.interlaced_pixels = w_inter;
        n_out.row_end           = w_row_end;
        n_out.row_changed       = w_row_end && w_row_diff;
        n_out.frame_end         = w_frame_end;
        n_out.box_x             = '0;
        n_out.box_y             = '0;
        n_out.box_width         = '0;
        n_out.box_height        = '0;
        if (w_frame_end) begin
            if (w_col_any) begin
                n_out.box_x     = w_first_col;
                n_out.box_width = w_last_col - w_first_col + COORD_W'(1);
            end else begin
                n_out.box_x     = w_bounds.empty_x[COORD_W-1:0];
            end
            if (w_row_any) begin
                n_out.box_y      = w_first_row;
                n_out.box_height = w_last_row - w_first_row + COORD_W'(1);
            end else begin
                n_out.box_y      = w_bounds.empty_y[COORD_W-1:0];
            end
        end
    end

    always_comb begin
        n_col_cursor = r_col_cursor;
        n_row_cursor = r_row_cursor;
        n_row_diff   = r_row_diff;
        n_col_any    = r_col_any;
        n_row_any    = r_row_any;
        n_first_col  = r_first_col;
        n_last_col   = r_last_col;
        n_first_row  = r_first_row;
        n_last_row   = r_last_row;
        if (w_ctl.restart) begin
            n_col_cursor = w_ctl.seg_start;
            n_row_cursor = w_ctl.crop_top;
            n_row_diff   = 1'b0;
            n_col_any    = 1'b0;
            n_row_any    = 1'b0;
        end else if (w_fire) begin
            if (w_frame_end) begin
                // frame done: back to the top-left of the segment
                n_col_cursor = w_bounds.seg_start[COORD_W-1:0];
                n_row_cursor = w_bounds.crop_top[COORD_W-1:0];
                n_row_diff   = 1'b0;
                n_col_any    = 1'b0;
                n_row_any    = 1'b0;
            end else begin
                n_col_any   = w_col_any;
                n_first_col = w_first_col;
                n_last_col  = w_last_col;
                n_row_any   = w_row_any;
                n_first_row = w_first_row;
                n_last_row  = w_last_row;
                if (w_row_end) begin
                    n_col_cursor = w_bounds.seg_start[COORD_W-1:0];
                    n_row_cursor = r_row_cursor + COORD_W'(1);
                    n_row_diff   = 1'b0;
                end else begin
                    n_col_cursor = r_col_cursor + COORD_W'(LANES);
                    n_row_diff   = w_row_diff;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cursor <= RST_BOUNDS.seg_start[COORD_W-1:0];
            r_row_cursor <= RST_BOUNDS.crop_top[COORD_W-1:0];
            r_row_diff   <= 1'b0;
            r_col_any    <= 1'b0;
            r_row_any    <= 1'b0;
            r_first_col  <= '0;
            r_last_col   <= '0;
            r_first_row  <= '0;
            r_last_row   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_col_cursor <= n_col_cursor;
            r_row_cursor <= n_row_cursor;
            r_row_diff   <= n_row_diff;
            r_col_any    <= n_col_any;
            r_row_any    <= n_row_any;
            r_first_col  <= n_first_col;
            r_last_col   <= n_last_col;
            r_first_row  <= n_first_row;
            r_last_row   <= n_last_row;
            if (!o_in_stall) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    // output payload, loaded on each accepted beat
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_frame_has_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_end |-> o_out_data.row_end)
        else $error("frame_end without row_end");

    a_cursor_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col_cursor[LANE_IDX_W-1:0] == '0)
        else $error("column cursor off lane alignment");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_frame_end |=>
            (r_col_cursor == w_bounds.seg_start[COORD_W-1:0])
            && (r_row_cursor == w_bounds.crop_top[COORD_W-1:0]) && !r_col_any && !r_row_any)
        else $error("scan state not restarted after frame end");
`endif

endmodule

`default_nettype wire
